FILE: hdl/reader_writer_lock_arbiter_unit_defines.svh
// Assertion macros shared by the reader-writer lock checker.
`ifndef READER_WRITER_LOCK_ARBITER_UNIT_DEFINES_SVH
`define READER_WRITER_LOCK_ARBITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwl assertion failed");

`endif

FILE: hdl/rwl_pkg.sv
// Types, codes and default sizes for the reader-writer lock arbiter.
package rwl_pkg;

	localparam int QUEUE_DEPTH_DEF      = 16;
	localparam int ID_WIDTH_DEF         = 8;
	localparam int READER_COUNT_MAX_DEF = 255;
	localparam int MAX_RESULTS          = 16;

	localparam int MODE_W   = 2;
	localparam int REQ_ID_W = 8;
	localparam int STATUS_W = 3;
	localparam int TID_W    = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENTER_READ  = 2'd0,
		MODE_ENTER_WRITE = 2'd1,
		MODE_EXIT_READ   = 2'd2,
		MODE_EXIT_WRITE  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_REJECTED = 3'd2,
		ST_RELEASED = 3'd3,
		ST_MISUSE   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} state_t;

	// Queue status seen by the arbiter.
	typedef struct packed {
		logic empty;
		logic one;
		logic full;
	} qstat_t;

endpackage

FILE: hdl/rwl_queue.sv
// Id wait queue: circular buffer in a synchronous memory, head entry registered.
module rwl_queue import rwl_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_W  = ID_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [ID_W-1:0] push_id,
	input  logic            pop,
	output logic [ID_W-1:0] head_id,
	output qstat_t          qstat
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int OccW = $clog2(DEPTH + 1);

	logic [ID_W-1:0] mem [DEPTH];
	logic [PtrW-1:0] head_q, tail_q, head_d;
	logic [OccW-1:0] occ_q;
	logic [ID_W-1:0] head_id_q;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		nxt = (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
	endfunction

	// read address tracks the head after this cycle's pop
	assign head_d = pop ? nxt(head_q) : head_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_id;
		end
		head_id_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			head_q <= head_d;
			if (push) begin
				tail_q <= nxt(tail_q);
			end
			if (push && !pop) begin
				occ_q <= OccW'(occ_q + 1'b1);
			end else if (pop && !push) begin
				occ_q <= OccW'(occ_q - 1'b1);
			end
		end
	end

	assign head_id     = head_id_q;
	assign qstat.empty = (occ_q == '0);
	assign qstat.one   = (occ_q == OccW'(1));
	assign qstat.full  = (occ_q == OccW'(DEPTH));

endmodule

FILE: hdl/reader_writer_lock_arbiter_unit.sv
// Reader-writer lock arbiter: top level with request sequencer and result register.
//
// Reader-writer lock manager with FIFO wait queues for readers and writers.
// Each request beat (mode, requester_id) is taken when in_valid is high and
// in_stall is low; in_stall stays high while a request is being worked on.
// A request is captured in S_IDLE while both queue memories present their
// head ids; S_EXEC decides, updates the lock state and loads the result
// register. A writer exit that wakes N waiting readers issues one grant beat
// per cycle unless the output stalls, bounded by the single read port of the
// reader queue memory that fetches the next head each cycle. Stalls on the
// output hold the sequencer in place. Every request produces at least one
// result beat; the final beat of a request carries last. Queue memories hold
// no reset value and need no clearing pass: only occupied entries are read.
// Ids are the low ID_WIDTH bits of requester_id, zero extended on output.
module reader_writer_lock_arbiter_unit import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH         = ID_WIDTH_DEF,
	parameter int READER_COUNT_MAX = READER_COUNT_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [REQ_ID_W-1:0] requester_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TID_W-1:0]    thread_id,
	output logic                grant_is_write,
	output logic                last
);

	// widths
	localparam int CntW = $clog2(READER_COUNT_MAX + 1);
	localparam int NW   = $clog2(MAX_RESULTS);
	localparam int ExtW = (ID_WIDTH > TID_W) ? ID_WIDTH : TID_W;

	// sequencer state
	state_t              state_q, state_d;
	logic [NW-1:0]       n_q, n_d;          // grants issued in the current drain
	logic [CntW-1:0]     cnt_q, cnt_d;      // active readers
	logic                wact_q, wact_d;    // writer holds the lock

	// captured request
	mode_t               mode_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [ExtW-1:0]     req_ext;

	// queue interface
	logic                r_push, r_pop, w_push, w_pop;
	logic [ID_WIDTH-1:0] r_head, w_head;
	qstat_t              rq, wq;

	// result
	logic                take, emit, drain, drain_last;
	status_t             res_status;
	logic [ID_WIDTH-1:0] res_tid;
	logic                res_wr, res_last;
	logic [ExtW-1:0]     res_ext;

	logic                out_valid_q;
	status_t             status_q;
	logic [TID_W-1:0]    thread_id_q;
	logic                grant_is_write_q, last_q;

	logic                in_acc;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign take     = !out_valid_q || !out_stall;
	assign req_ext  = ExtW'(requester_id);

	rwl_queue #(.DEPTH(QUEUE_DEPTH), .ID_W(ID_WIDTH)) u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (r_push),
		.push_id (id_q),
		.pop     (r_pop),
		.head_id (r_head),
		.qstat   (rq)
	);

	rwl_queue #(.DEPTH(QUEUE_DEPTH), .ID_W(ID_WIDTH)) u_wq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (w_push),
		.push_id (id_q),
		.pop     (w_pop),
		.head_id (w_head),
		.qstat   (wq)
	);

	// drain ends when the queue runs dry, the beat budget is spent or
	// the reader count reaches its ceiling
	assign drain_last = rq.one || (n_q == NW'(MAX_RESULTS - 1)) ||
		(cnt_q >= CntW'(READER_COUNT_MAX - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			cnt_q   <= '0;
			wact_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			cnt_q   <= cnt_d;
			wact_q  <= wact_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode_t'(mode);
			id_q   <= req_ext[ID_WIDTH-1:0];
		end
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		cnt_d      = cnt_q;
		wact_d     = wact_q;
		r_push     = 1'b0;
		w_push     = 1'b0;
		r_pop      = 1'b0;
		w_pop      = 1'b0;
		emit       = 1'b0;
		drain      = 1'b0;
		res_status = ST_GRANTED;
		res_tid    = id_q;
		res_wr     = 1'b0;
		res_last   = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
					n_d     = '0;
				end
			end
			S_EXEC: begin
				if (take) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					case (mode_q)
						MODE_ENTER_READ: begin
							if (!wact_q && wq.empty) begin
								if (cnt_q >= CntW'(READER_COUNT_MAX)) begin
									res_status = ST_REJECTED;
								end else begin
									cnt_d      = CntW'(cnt_q + 1'b1);
									res_status = ST_GRANTED;
								end
							end else if (rq.full) begin
								res_status = ST_REJECTED;
							end else begin
								r_push     = 1'b1;
								res_status = ST_QUEUED;
							end
						end
						MODE_ENTER_WRITE: begin
							res_wr = 1'b1;
							if (cnt_q == '0 && !wact_q) begin
								wact_d     = 1'b1;
								res_status = ST_GRANTED;
							end else if (wq.full) begin
								res_status = ST_REJECTED;
							end else begin
								w_push     = 1'b1;
								res_status = ST_QUEUED;
							end
						end
						MODE_EXIT_READ: begin
							if (cnt_q == '0) begin
								res_status = ST_MISUSE;
							end else begin
								cnt_d = CntW'(cnt_q - 1'b1);
								// last reader out hands the lock to the front writer
								if (cnt_q == CntW'(1) && !wq.empty) begin
									wact_d     = 1'b1;
									w_pop      = 1'b1;
									res_status = ST_GRANTED;
									res_tid    = w_head;
									res_wr     = 1'b1;
								end else begin
									res_status = ST_RELEASED;
								end
							end
						end
						MODE_EXIT_WRITE: begin
							res_wr = 1'b1;
							if (!wact_q) begin
								res_status = ST_MISUSE;
							end else if (!rq.empty) begin
								if (cnt_q >= CntW'(READER_COUNT_MAX)) begin
									wact_d     = 1'b0;
									res_status = ST_RELEASED;
								end else begin
									drain = 1'b1;
								end
							end else if (!wq.empty) begin
								w_pop      = 1'b1;
								res_status = ST_GRANTED;
								res_tid    = w_head;
							end else begin
								wact_d     = 1'b0;
								res_status = ST_RELEASED;
							end
						end
						default: begin
							res_status = ST_MISUSE;
						end
					endcase
				end
			end
			S_DRAIN: begin
				if (take) begin
					emit  = 1'b1;
					drain = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// one reader grant per beat from the queue head
		if (drain) begin
			wact_d     = 1'b0;
			cnt_d      = CntW'(cnt_q + 1'b1);
			r_pop      = 1'b1;
			res_status = ST_GRANTED;
			res_tid    = r_head;
			res_wr     = 1'b0;
			res_last   = drain_last;
			state_d    = drain_last ? S_IDLE : S_DRAIN;
			n_d        = NW'(n_q + 1'b1);
		end
	end

	assign res_ext = ExtW'(res_tid);

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q         <= res_status;
			thread_id_q      <= res_ext[TID_W-1:0];
			grant_is_write_q <= res_wr;
			last_q           <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign thread_id      = thread_id_q;
	assign grant_is_write = grant_is_write_q;
	assign last           = last_q;

endmodule

FILE: hdl/rwl_checker.sv
// Port-level checker for the reader-writer lock arbiter, bound to the top level.
`include "reader_writer_lock_arbiter_unit_defines.svh"

module rwl_checker import rwl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [MODE_W-1:0]   mode,
	input logic [REQ_ID_W-1:0] requester_id,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [TID_W-1:0]    thread_id,
	input logic                grant_is_write,
	input logic                last
);

	// a stalled result beat holds
	`RWL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(thread_id) && $stable(grant_is_write) && $stable(last))

	// a stalled request beat holds
	`RWL_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(mode) && $stable(requester_id))

	// one request in flight: the cycle after a request beat is taken, input stalls
	`RWL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// status codes stay in the defined range
	`RWL_ASSERT_IMPL(a_status_range, clk, arst_n, out_valid, status <= ST_MISUSE)

	// only reader grants of a drain can be non-final beats
	`RWL_ASSERT_IMPL(a_nonlast_is_read_grant, clk, arst_n, out_valid && !last, status == ST_GRANTED && !grant_is_write)

endmodule

bind reader_writer_lock_arbiter_unit rwl_checker u_rwl_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the reader-writer lock arbiter: queued stimulus, lock predictor, beat checker.
module tb_top;
	import rwl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The id is the low ID_WIDTH bits of requester_id, zero extended on the way out.
	localparam logic [REQ_ID_W-1:0] ID_MASK = REQ_ID_W'((1 << ID_WIDTH_DEF) - 1);
	// Generous ceiling.
	localparam int CYCLE_LIMIT = 400000;
	// Worst case from the top-level notes: a request is captured and decided,
	// then a drain of up to MAX_RESULTS grant beats.
	localparam int SETTLE_CYCLES = 4 * MAX_RESULTS + 8;

	// One request beat waiting to be driven.
	typedef struct packed {
		mode_t                op;
		logic [REQ_ID_W-1:0]  rid;
	} lock_req_t;

	// One result beat that the lock is expected to produce.
	typedef struct packed {
		status_t           st;
		logic [TID_W-1:0]  tid;
		logic              wr;
		logic              fin;
	} lock_outcome_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [MODE_W-1:0]   mode = '0;
	logic [REQ_ID_W-1:0] requester_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TID_W-1:0]    thread_id;
	logic                grant_is_write;
	logic                last;

	reader_writer_lock_arbiter_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.requester_id   (requester_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.thread_id      (thread_id),
		.grant_is_write (grant_is_write),
		.last           (last)
	);

	// Requests not yet driven, and result beats predicted but not yet seen.
	lock_req_t     request_backlog[$];
	lock_outcome_t pending_outcomes[$];

	// Predicted lock state: holders and the two FIFO wait lines.
	int unsigned      readers_holding = 0;
	logic             writer_holding = 1'b0;
	logic [TID_W-1:0] readers_waiting[$];
	logic [TID_W-1:0] writers_waiting[$];

	// Idle knobs, in percent, changed per phase.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	logic        req_taken = 1'b0;
	lock_req_t   drive_req;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          phase_items = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	//--------------------------------------------------------------------
	// Predictor
	//--------------------------------------------------------------------

	function automatic void expect_beat(status_t st, logic [TID_W-1:0] tid, logic wr,
			logic fin);
		lock_outcome_t o;
		o.st  = st;
		o.tid = tid;
		o.wr  = wr;
		o.fin = fin;
		pending_outcomes.push_back(o);
	endfunction

	// Advance the lock for one accepted request and queue the beats it causes.
	function automatic void arbitrate(mode_t op, logic [REQ_ID_W-1:0] rid);
		logic [TID_W-1:0] tid;
		int unsigned      wake;
		tid = TID_W'(rid & ID_MASK);
		case (op)
			MODE_ENTER_READ: begin
				if (!writer_holding && writers_waiting.size() == 0) begin
					// Free to share, unless the reader count is already at its ceiling.
					if (readers_holding >= READER_COUNT_MAX_DEF) begin
						expect_beat(ST_REJECTED, tid, 1'b0, 1'b1);
					end else begin
						readers_holding++;
						expect_beat(ST_GRANTED, tid, 1'b0, 1'b1);
					end
				end else if (readers_waiting.size() < QUEUE_DEPTH_DEF) begin
					readers_waiting.push_back(tid);
					expect_beat(ST_QUEUED, tid, 1'b0, 1'b1);
				end else begin
					expect_beat(ST_REJECTED, tid, 1'b0, 1'b1);
				end
			end
			MODE_ENTER_WRITE: begin
				if (readers_holding == 0 && !writer_holding) begin
					writer_holding = 1'b1;
					expect_beat(ST_GRANTED, tid, 1'b1, 1'b1);
				end else if (writers_waiting.size() < QUEUE_DEPTH_DEF) begin
					writers_waiting.push_back(tid);
					expect_beat(ST_QUEUED, tid, 1'b1, 1'b1);
				end else begin
					expect_beat(ST_REJECTED, tid, 1'b1, 1'b1);
				end
			end
			MODE_EXIT_READ: begin
				if (readers_holding == 0) begin
					expect_beat(ST_MISUSE, tid, 1'b0, 1'b1);
				end else begin
					readers_holding--;
					// Last reader out hands the lock to the oldest waiting writer.
					if (readers_holding == 0 && writers_waiting.size() != 0) begin
						writer_holding = 1'b1;
						expect_beat(ST_GRANTED, writers_waiting.pop_front(), 1'b1, 1'b1);
					end else begin
						expect_beat(ST_RELEASED, tid, 1'b0, 1'b1);
					end
				end
			end
			default: begin
				if (!writer_holding) begin
					expect_beat(ST_MISUSE, tid, 1'b1, 1'b1);
				end else begin
					writer_holding = 1'b0;
					// Waiting readers go first, bounded by the beat budget and the count ceiling.
					wake = readers_waiting.size();
					if (wake > MAX_RESULTS)
						wake = MAX_RESULTS;
					if (wake > READER_COUNT_MAX_DEF - readers_holding)
						wake = READER_COUNT_MAX_DEF - readers_holding;
					if (wake != 0) begin
						for (int unsigned i = 0; i < wake; i++) begin
							readers_holding++;
							expect_beat(ST_GRANTED, readers_waiting.pop_front(), 1'b0,
								i == wake - 1);
						end
					end else if (readers_waiting.size() == 0 && writers_waiting.size() != 0) begin
						writer_holding = 1'b1;
						expect_beat(ST_GRANTED, writers_waiting.pop_front(), 1'b1, 1'b1);
					end else begin
						expect_beat(ST_RELEASED, tid, 1'b1, 1'b1);
					end
				end
			end
		endcase
	endfunction

	//--------------------------------------------------------------------
	// Checker
	//--------------------------------------------------------------------

	function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $realtime, fname, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_beat();
		lock_outcome_t want;
		if (pending_outcomes.size() == 0) begin
			$display("%0t ns: stray beat, expected none, got status %0h tid %0h wr %0b last %0b",
				$realtime, status, thread_id, grant_is_write, last);
			mismatch_count++;
		end else begin
			want = pending_outcomes.pop_front();
			check_field("status", 8'(want.st), 8'(status));
			check_field("thread_id", 8'(want.tid), 8'(thread_id));
			check_field("grant_is_write", 8'(want.wr), 8'(grant_is_write));
			check_field("last", 8'(want.fin), 8'(last));
		end
	endfunction

	//--------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge. A request beat is
	// predicted the moment it is taken; a result beat is checked the moment
	// it leaves. A request is captured, decided, then registered as a
	// result, so no result shares an edge with the request that caused it.
	//--------------------------------------------------------------------

	always @(posedge clk) begin
		req_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				arbitrate(mode_t'(mode), requester_id);
			if (out_valid && !out_stall)
				check_beat();
		end
	end

	//--------------------------------------------------------------------
	// Driver: everything changes at the falling edge. A held request stays
	// put until it is taken; a new one is offered only after that, or when
	// the line is idle, so valid is never dropped and raised in one step.
	//--------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_req = request_backlog.pop_front();
				in_valid     <= 1'b1;
				mode         <= drive_req.op;
				requester_id <= drive_req.rid;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("reader_writer_lock_arbiter_unit: mismatch");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// Stimulus
	//--------------------------------------------------------------------

	function automatic void queue_req(mode_t op, logic [REQ_ID_W-1:0] rid);
		lock_req_t r;
		r.op  = op;
		r.rid = rid;
		request_backlog.push_back(r);
		phase_items++;
	endfunction

	function automatic logic [REQ_ID_W-1:0] any_id();
		return REQ_ID_W'($urandom_range(255));
	endfunction

	// Shared readers come and go.
	function automatic void reader_wave(int n);
		for (int i = 0; i < n; i++)
			queue_req(MODE_ENTER_READ, any_id());
		for (int i = 0; i < n; i++)
			queue_req(MODE_EXIT_READ, any_id());
	endfunction

	// A writer holds the lock while readers and writers pile up behind it,
	// sometimes past the queue depth. Its exit drains the readers; their
	// exits pass the lock down the writer line.
	function automatic void writer_wave(int rd, int wr);
		queue_req(MODE_ENTER_WRITE, any_id());
		for (int i = 0; i < rd; i++)
			queue_req(MODE_ENTER_READ, any_id());
		for (int i = 0; i < wr; i++)
			queue_req(MODE_ENTER_WRITE, any_id());
		queue_req(MODE_EXIT_WRITE, any_id());
		for (int i = 0; i < rd && i < QUEUE_DEPTH_DEF; i++)
			queue_req(MODE_EXIT_READ, any_id());
		for (int i = 0; i < wr && i < QUEUE_DEPTH_DEF; i++)
			queue_req(MODE_EXIT_WRITE, any_id());
	endfunction

	// Readers hold, a writer waits, and later readers queue behind that writer.
	function automatic void shared_then_write(int held, int late);
		for (int i = 0; i < held; i++)
			queue_req(MODE_ENTER_READ, any_id());
		queue_req(MODE_ENTER_WRITE, any_id());
		for (int i = 0; i < late; i++)
			queue_req(MODE_ENTER_READ, any_id());
		for (int i = 0; i < held; i++)
			queue_req(MODE_EXIT_READ, any_id());
		queue_req(MODE_EXIT_WRITE, any_id());
		for (int i = 0; i < late; i++)
			queue_req(MODE_EXIT_READ, any_id());
	endfunction

	// Mostly well-formed lock sessions with random ids, some raw noise.
	function automatic void random_traffic(int target);
		int pick;
		phase_items = 0;
		while (phase_items < target) begin
			pick = $urandom_range(99);
			if (pick < 25)
				reader_wave($urandom_range(1, 6));
			else if (pick < 60)
				writer_wave(($urandom_range(4) == 0) ? $urandom_range(15, 18) : $urandom_range(5),
					($urandom_range(5) == 0) ? $urandom_range(15, 17) : $urandom_range(3));
			else if (pick < 82)
				shared_then_write($urandom_range(1, 4), $urandom_range(4));
			else
				for (int i = $urandom_range(1, 3); i > 0; i--)
					queue_req(mode_t'($urandom_range(3)), any_id());
		end
	endfunction

	// Block until every request is taken and every beat has come out.
	task automatic wait_drained();
		while (request_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass, no idling. Misuse on an idle lock for both exits.
		queue_req(MODE_EXIT_READ, 8'h00);
		queue_req(MODE_EXIT_WRITE, 8'hFF);
		// Two readers share; a writer queues behind them, a reader behind the writer.
		queue_req(MODE_ENTER_READ, 8'h00);
		queue_req(MODE_ENTER_READ, 8'hFF);
		queue_req(MODE_ENTER_WRITE, 8'h55);
		queue_req(MODE_ENTER_READ, 8'hAA);
		// Plain release, then the last reader out hands over to the writer.
		queue_req(MODE_EXIT_READ, 8'h01);
		queue_req(MODE_EXIT_READ, 8'h02);
		queue_req(MODE_ENTER_WRITE, 8'h11);
		// Writer exit wakes the single waiting reader.
		queue_req(MODE_EXIT_WRITE, 8'h55);
		queue_req(MODE_EXIT_READ, 8'hAA);
		// Writer exit with nobody waiting.
		queue_req(MODE_EXIT_WRITE, 8'h11);
		// Writer exit with only a writer waiting.
		queue_req(MODE_ENTER_WRITE, 8'h01);
		queue_req(MODE_ENTER_WRITE, 8'h80);
		queue_req(MODE_EXIT_WRITE, 8'h01);
		queue_req(MODE_EXIT_WRITE, 8'h80);

		// Random phases: no idling, sender gaps, receiver stalls, then both.
		random_traffic(30);
		wait_drained();

		send_idle_pct  = 59;
		recv_stall_pct = 0;
		random_traffic(30);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 59;
		random_traffic(30);
		wait_drained();

		send_idle_pct  = 18;
		recv_stall_pct = 18;
		random_traffic(30);
		wait_drained();

		// Give any stray beat time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("reader_writer_lock_arbiter_unit: match");
		else
			$display("reader_writer_lock_arbiter_unit: mismatch");
		$finish;
	end

endmodule
